// File: hdl/vtu_pkg.sv
// Shared types, constants and helpers for the vertex transform unit.
// No dependencies; used by every module of the block.
package vtu_pkg;

  // Q16.16 signed element and its full-precision product
  typedef logic signed [31:0] q16_t;
  typedef logic signed [63:0] prod_t;

  localparam int unsigned NumRows  = 4;
  localparam int unsigned NumElems = NumRows * NumRows;
  localparam int unsigned ElemIdxW = $clog2(NumElems);

  // 1.0 in Q16.16
  localparam q16_t QOne  = 32'sh0001_0000;
  localparam q16_t QZero = 32'sh0000_0000;

  // Column-major: index = column * 4 + row
  typedef q16_t [NumElems-1:0] mat_t;
  typedef q16_t [NumRows-1:0]  vec_t;
  typedef prod_t [NumRows-1:0] prod_row_t;

  typedef enum logic [1:0] {
    KIND_LOAD_ELEM   = 2'd0,
    KIND_LOAD_IDENT  = 2'd1,
    KIND_CLEAR_TRANS = 2'd2,
    KIND_TRANSFORM   = 2'd3
  } kind_e;

  // Matrix update request from the input side
  typedef struct packed {
    logic                valid;
    kind_e               kind;
    logic [ElemIdxW-1:0] index;
    q16_t                value;
  } mat_cmd_t;

  // Identity: diagonal elements are those whose column equals their row
  function automatic mat_t identity_mat();
    mat_t                m;
    logic [ElemIdxW-1:0] idx;
    for (int i = 0; i < NumElems; i++) begin
      idx  = ElemIdxW'(i);
      m[i] = (idx[1:0] == idx[3:2]) ? QOne : QZero;
    end
    return m;
  endfunction

endpackage

// File: hdl/vertex_transform_unit_top.sv
// Vertex transform unit top level: matrix store, product stage, sum/saturate stage.
// Depends on vtu_pkg, vtu_matrix and vtu_row_sum.
//
//  channel  | dir | tdata (low bit up)                         | tuser
//  ---------+-----+--------------------------------------------+-----------
//  s_axis   | in  | elem_index, elem_value, vec_x..vec_w, pad  | kind
//  m_axis   | out | out_x, out_y, out_z, out_w                 | saturated
//
// One item per cycle in steady state while m_axis does not stall. A transform item
// passes through an input register, a product register (16 parallel
// 32x32 multipliers) and a result register (four-way add, shift, saturate).
// Matrix updates take effect at the edge that accepts them; a transform sees
// every update accepted before it. Reset loads the identity matrix and empties
// the pipeline. A stall on m_axis freezes all stages, so s_axis_tready drops
// only while a result waits with m_axis_tready low.
module vertex_transform_unit_top import vtu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [3:0] elem_index, [35:4] elem_value, [67:36] vec_x, [99:68] vec_y,
  // [131:100] vec_z, [163:132] vec_w, [167:164] zero pad
  input  logic [167:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
  output logic [127:0] m_axis_tdata,
  // [0] saturated
  output logic         m_axis_tuser
);

  // whole pipeline moves together; it may advance unless a result is stuck
  logic adv;
  logic in_acc;
  kind_e in_kind;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign in_acc        = s_axis_tvalid && adv;
  assign in_kind       = kind_e'(s_axis_tuser);

  // ---- matrix store ----
  mat_cmd_t cmd;
  mat_t     mat;

  assign cmd.valid = in_acc && (in_kind != KIND_TRANSFORM);
  assign cmd.kind  = in_kind;
  assign cmd.index = s_axis_tdata[3:0];
  assign cmd.value = q16_t'(s_axis_tdata[35:4]);

  vtu_matrix u_matrix (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .mat_o  (mat)
  );

  // ---- stage 1: input vector register ----
  logic vld1_q;
  vec_t vec1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q <= 1'b0;
    end else if (adv) begin
      vld1_q <= in_acc && (in_kind == KIND_TRANSFORM);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      vec1_q[0] <= q16_t'(s_axis_tdata[67:36]);
      vec1_q[1] <= q16_t'(s_axis_tdata[99:68]);
      vec1_q[2] <= q16_t'(s_axis_tdata[131:100]);
      vec1_q[3] <= q16_t'(s_axis_tdata[163:132]);
    end
  end

  // ---- stage 2: products, grouped by output row ----
  // The matrix is read here; any update accepted with this edge lands after.
  logic      vld2_q;
  prod_row_t prod_d [NumRows];
  prod_row_t prod_q [NumRows];

  always_comb begin
    for (int r = 0; r < NumRows; r++) begin
      for (int c = 0; c < NumRows; c++) begin
        prod_d[r][c] = prod_t'(mat[c*NumRows + r]) * prod_t'(vec1_q[c]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld2_q <= 1'b0;
    end else if (adv) begin
      vld2_q <= vld1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod_q <= prod_d;
    end
  end

  // ---- stage 3: sum, floor shift, saturate into the result register ----
  vec_t               res_d;
  logic [NumRows-1:0] sat_d;
  vec_t               res_q;
  logic               sat_q;
  logic               vld3_q;

  for (genvar r = 0; r < NumRows; r++) begin : g_row
    vtu_row_sum u_row_sum (
      .prods_i (prod_q[r]),
      .res_o   (res_d[r]),
      .sat_o   (sat_d[r])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld3_q <= 1'b0;
    end else if (adv) begin
      vld3_q <= vld2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
      sat_q <= |sat_d;
    end
  end

  assign m_axis_tvalid = vld3_q;
  assign m_axis_tdata  = {res_q[3], res_q[2], res_q[1], res_q[0]};
  assign m_axis_tuser  = sat_q;

endmodule

// File: hdl/vtu_matrix.sv
// Transform matrix store: 16 Q16.16 elements, reset to identity.
// Depends on vtu_pkg for the command struct and matrix types.
module vtu_matrix import vtu_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mat_cmd_t cmd_i,
  output mat_t     mat_o
);

  mat_t mat_q, mat_d;

  always_comb begin
    mat_d = mat_q;
    if (cmd_i.valid) begin
      unique case (cmd_i.kind)
        KIND_LOAD_ELEM:   mat_d[cmd_i.index] = cmd_i.value;
        KIND_LOAD_IDENT:  mat_d = identity_mat();
        KIND_CLEAR_TRANS: begin
          // translation column, rows x..z
          mat_d[12] = QZero;
          mat_d[13] = QZero;
          mat_d[14] = QZero;
        end
        KIND_TRANSFORM:   mat_d = mat_q;
        default:          mat_d = mat_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mat_q <= identity_mat();
    end else begin
      mat_q <= mat_d;
    end
  end

  assign mat_o = mat_q;

endmodule

// File: hdl/vtu_row_sum.sv
// One output component: sum of four products, floor shift by 16, saturate.
// Depends on vtu_pkg for the product and element types.
module vtu_row_sum import vtu_pkg::*; (
  input  prod_row_t prods_i,
  output q16_t      res_o,
  output logic      sat_o
);

  // four 64-bit signed products need 66 bits for an exact sum
  logic signed [65:0] sum;
  logic               ovf;

  always_comb begin
    sum = 66'(prods_i[0]) + 66'(prods_i[1]) + 66'(prods_i[2]) + 66'(prods_i[3]);
    // sum >>> 16 fits 32 bits signed only if bits 65..47 all match
    ovf = !((&sum[65:47]) || !(|sum[65:47]));
    if (!ovf) begin
      res_o = q16_t'(sum[47:16]);
    end else if (sum[65]) begin
      res_o = 32'sh8000_0000;
    end else begin
      res_o = 32'sh7FFF_FFFF;
    end
    sat_o = ovf;
  end

endmodule

// File: tb/sv/vtu_transform_checker.sv
// Scoreboard for the vertex transform unit: tracks the matrix from accepted
// items, predicts each transform result and compares it. Depends on vtu_pkg.
module vtu_transform_checker import vtu_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  // [3:0] elem_index, [35:4] elem_value, [67:36] vec_x, [99:68] vec_y,
  // [131:100] vec_z, [163:132] vec_w, [167:164] zero pad
  input  logic [167:0] s_axis_tdata,
  // [1:0] kind
  input  logic [1:0]   s_axis_tuser,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
  input  logic [127:0] m_axis_tdata,
  // [0] saturated
  input  logic         m_axis_tuser,
  output int           fail_count_o,
  output int           pending_o
);

  typedef struct packed {
    vec_t comp;
    logic sat;
  } vertex_out_t;

  // exact four-product sums need 66 bits
  typedef logic signed [65:0] wide_t;
  localparam wide_t SumMax = 66'sd2147483647;
  localparam wide_t SumMin = -66'sd2147483648;

  mat_t        xform_mat;
  vertex_out_t vertex_q[$];
  int          fails;
  string       comp_name[NumRows] = '{"out_x", "out_y", "out_z", "out_w"};

  function automatic mat_t unit_matrix();
    mat_t m;
    for (int i = 0; i < NumElems; i++) begin
      m[i] = (i % 5 == 0) ? QOne : QZero;
    end
    return m;
  endfunction

  // floor((sum over c of m[c][r] * v[c]) / 2^16), clipped to 32 bits
  function automatic vertex_out_t transform_vertex(mat_t m, vec_t v);
    vertex_out_t res;
    wide_t       acc;
    wide_t       me;
    wide_t       ve;
    wide_t       shifted;
    res.sat = 1'b0;
    for (int r = 0; r < NumRows; r++) begin
      acc = '0;
      for (int c = 0; c < NumRows; c++) begin
        me  = $signed(m[c*NumRows+r]);
        ve  = $signed(v[c]);
        acc = acc + me * ve;
      end
      shifted = acc >>> 16;
      if (shifted > SumMax) begin
        shifted = SumMax;
        res.sat = 1'b1;
      end else if (shifted < SumMin) begin
        shifted = SumMin;
        res.sat = 1'b1;
      end
      res.comp[r] = shifted[31:0];
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    vertex_out_t want;
    vec_t        got;
    if (!rst_ni) begin
      xform_mat = unit_matrix();
      vertex_q.delete();
      fails     = 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        case (kind_e'(s_axis_tuser))
          KIND_LOAD_ELEM: begin
            xform_mat[s_axis_tdata[3:0]] = s_axis_tdata[35:4];
          end
          KIND_LOAD_IDENT: begin
            xform_mat = unit_matrix();
          end
          KIND_CLEAR_TRANS: begin
            // translation is column 3, rows 0 to 2
            for (int r = 0; r < NumRows - 1; r++) xform_mat[NumElems-NumRows+r] = QZero;
          end
          KIND_TRANSFORM: begin
            vertex_q.push_back(transform_vertex(xform_mat, s_axis_tdata[163:36]));
          end
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata;
        if (vertex_q.size() == 0) begin
          $error("unexpected result: tdata %h tuser %b", m_axis_tdata, m_axis_tuser);
          fails++;
        end else begin
          want = vertex_q.pop_front();
          for (int r = 0; r < NumRows; r++) begin
            if (got[r] !== want.comp[r]) begin
              $error("%s mismatch: expected %h, actual %h", comp_name[r], want.comp[r],
                     got[r]);
              fails++;
            end
          end
          if (m_axis_tuser !== want.sat) begin
            $error("saturated mismatch: expected %b, actual %b", want.sat, m_axis_tuser);
            fails++;
          end
        end
      end
    end
    fail_count_o <= fails;
    pending_o    <= vertex_q.size();
  end

endmodule

// File: tb/sv/vertex_transform_unit_top_test.sv
// Top of the vertex transform unit testbench: clock, reset, stimulus, verdict.
// Depends on vtu_pkg, vertex_transform_unit_top and vtu_transform_checker.
module vertex_transform_unit_top_test;
  import vtu_pkg::*;

  localparam int NumRandom  = 2000;
  localparam int NumPhases  = 4;
  localparam int PipeDepth  = 3;
  localparam int CycleLimit = 200000;

  logic         clk_i         = 1'b0;
  logic         rst_ni        = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  // [3:0] elem_index, [35:4] elem_value, [67:36] vec_x, [99:68] vec_y,
  // [131:100] vec_z, [163:132] vec_w, [167:164] zero pad
  logic [167:0] s_axis_tdata  = '0;
  // [1:0] kind
  logic [1:0]   s_axis_tuser  = KIND_LOAD_ELEM;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  // [31:0] out_x, [63:32] out_y, [95:64] out_z, [127:96] out_w
  logic [127:0] m_axis_tdata;
  // [0] saturated
  logic         m_axis_tuser;

  int fail_count;
  int pending_count;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // idling per phase: none, sender only, receiver only, both
  int phase_idle[NumPhases]  = '{0, 53, 0, 24};
  int phase_stall[NumPhases] = '{0, 0, 53, 24};

  vertex_transform_unit_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  vtu_transform_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost result ends here
  initial begin
    wait (cycle_count >= CycleLimit);
    $display("Regression FAIL");
    $finish;
  end

  function automatic vec_t mk_vec(q16_t x, q16_t y, q16_t z, q16_t w);
    vec_t v;
    v[0] = x;
    v[1] = y;
    v[2] = z;
    v[3] = w;
    return v;
  endfunction

  // Mix of small fixed-point values (mostly no clipping), full-range words
  // and the corner values
  function automatic q16_t rand_q16();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 4) begin
      return $signed($urandom_range(524288)) - 32'sd262144;
    end else if (pick < 8) begin
      return $urandom;
    end
    case ($urandom_range(6))
      0:       return 32'sh8000_0000;
      1:       return 32'sh7fff_ffff;
      2:       return QZero;
      3:       return QOne;
      4:       return -QOne;
      5:       return 32'sd1;
      default: return -32'sd1;
    endcase
  endfunction

  function automatic vec_t rand_vec();
    return mk_vec(rand_q16(), rand_q16(), rand_q16(), rand_q16());
  endfunction

  // Called at a rising edge; returns at the edge that accepts the item, with
  // tvalid still high so a back-to-back item needs no extra assignment
  task automatic send_item(input kind_e kind, input logic [3:0] idx, input q16_t value,
                           input vec_t vec);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= {4'b0000, vec, value, idx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold off the sender until every predicted vertex has come back.
  // The checker's count is registered, so look only from the next edge on.
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_count != 0) @(posedge clk_i);
  endtask

  initial begin
    kind_e       kind;
    int unsigned roll;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: identity pass-through of the corner values
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(QOne, 32'sh7fff_ffff, 32'sh8000_0000, -32'sd1));
    // one ulp below zero: the shift must round towards minus infinity
    send_item(KIND_LOAD_ELEM, 4'd0, -32'sd1, rand_vec());
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(32'sd1, QZero, QZero, QOne));
    // largest positive element times largest vector gives positive clipping
    send_item(KIND_LOAD_ELEM, 4'd15, 32'sh7fff_ffff, rand_vec());
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(QZero, QZero, QZero, 32'sh7fff_ffff));
    // translation at the extremes, then cleared
    send_item(KIND_LOAD_ELEM, 4'd12, 32'sh8000_0000, rand_vec());
    send_item(KIND_LOAD_ELEM, 4'd13, 32'sh7fff_ffff, rand_vec());
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom, mk_vec(QOne, QOne, QOne, QOne));
    send_item(KIND_CLEAR_TRANS, 4'($urandom), $urandom, rand_vec());
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom, mk_vec(QOne, QOne, QOne, QOne));
    send_item(KIND_LOAD_IDENT, 4'($urandom), $urandom, rand_vec());
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    // row 0 all most-negative: the exact sum reaches 2^64, beyond 64 bits
    for (int c = 0; c < 4; c++) begin
      send_item(KIND_LOAD_ELEM, 4'(c * 4), 32'sh8000_0000, rand_vec());
    end
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff));
    send_item(KIND_TRANSFORM, 4'($urandom), $urandom,
              mk_vec(-32'sd3, -32'sd65535, 32'sd65535, QZero));
    send_item(KIND_LOAD_IDENT, 4'($urandom), $urandom, rand_vec());
    drain_results();

    // Random: mostly transforms interleaved with element writes, so the
    // matrix drifts far from the identity between the rare reloads
    for (int p = 0; p < NumPhases; p++) begin
      send_idle_pct  = phase_idle[p];
      recv_stall_pct = phase_stall[p];
      for (int n = 0; n < NumRandom / NumPhases; n++) begin
        roll = $urandom_range(99);
        if (roll < 55) begin
          kind = KIND_TRANSFORM;
        end else if (roll < 90) begin
          kind = KIND_LOAD_ELEM;
        end else if (roll < 95) begin
          kind = KIND_LOAD_IDENT;
        end else begin
          kind = KIND_CLEAR_TRANS;
        end
        send_item(kind, 4'($urandom), rand_q16(), rand_vec());
      end
      drain_results();
    end

    recv_stall_pct = 0;
    repeat (PipeDepth * 4) @(posedge clk_i);
    if (fail_count == 0 && pending_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
